[sv/vgph_pkg.sv]
// Shared constants and types for the voice gate with pre-roll and hangover.
// Used by vgph_cell, vgph_chain and voice_gate_preroll_hangover; no dependencies.
package vgph_pkg;

    localparam int PREROLL_DEPTH_DEFAULT = 64;

    localparam int SAMPLE_W   = 16;
    localparam int LIMIT_W    = 7;
    localparam int HANGOVER_W = 20;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GATE_ENABLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PREROLL_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HANGOVER_LENGTH = 2'd2;

    // Register values after reset.
    localparam logic                  GATE_ENABLE_RST     = 1'b1;
    localparam logic [LIMIT_W-1:0]    PREROLL_LIMIT_RST   = 7'd64;
    localparam logic [HANGOVER_W-1:0] HANGOVER_LENGTH_RST = 20'd8000;

    // Control broadcast along the pre-roll chain.
    typedef struct packed {
        logic shift;  // every cell below the top takes its upper neighbor's sample; the top cell keeps its own
        logic wr_en;  // one cell, chosen by the write index, takes the new sample
    } t_chain_ctl;

endpackage

[sv/vgph_cell.sv]
// One storage cell of the pre-roll chain: holds a single audio sample.
// Depends on vgph_pkg for the sample width.
module vgph_cell (
    input  logic                           i_clk,
    input  logic                           i_shift,
    input  logic                           i_load,
    input  logic [vgph_pkg::SAMPLE_W-1:0]  i_wr_data,
    input  logic [vgph_pkg::SAMPLE_W-1:0]  i_nb_data,
    output logic [vgph_pkg::SAMPLE_W-1:0]  o_data
);

    logic [vgph_pkg::SAMPLE_W-1:0] r_data;
    logic [vgph_pkg::SAMPLE_W-1:0] n_data;

    // A direct write wins over the shift, so the newest sample can land in the
    // top occupied cell while the rest of the chain moves down by one.
    always_comb begin
        n_data = r_data;
        if (i_load) begin
            n_data = i_wr_data;
        end else if (i_shift) begin
            n_data = i_nb_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

[sv/vgph_chain.sv]
// Pre-roll chain: a row of vgph_cell instances, oldest sample in cell 0.
// Depends on vgph_pkg and vgph_cell.
module vgph_chain #(
    parameter int DEPTH = vgph_pkg::PREROLL_DEPTH_DEFAULT,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                           i_clk,
    input  vgph_pkg::t_chain_ctl           i_ctl,
    input  logic [IDX_W-1:0]               i_wr_idx,
    input  logic [vgph_pkg::SAMPLE_W-1:0]  i_wr_data,
    output logic [vgph_pkg::SAMPLE_W-1:0]  o_head
);

    logic [vgph_pkg::SAMPLE_W-1:0] w_cell [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [vgph_pkg::SAMPLE_W-1:0] w_nb;
        logic                          w_load;

        if (g == DEPTH - 1) begin : g_top
            assign w_nb = w_cell[g];
        end else begin : g_mid
            assign w_nb = w_cell[g+1];
        end

        assign w_load = i_ctl.wr_en && (i_wr_idx == IDX_W'(g));

        vgph_cell u_cell (
            .i_clk     (i_clk),
            .i_shift   (i_ctl.shift),
            .i_load    (w_load),
            .i_wr_data (i_wr_data),
            .i_nb_data (w_nb),
            .o_data    (w_cell[g])
        );
    end

    assign o_head = w_cell[0];

endmodule

[sv/voice_gate_preroll_hangover.sv]
// Voice gate with pre-roll and hangover: control, configuration and output register.
// Depends on vgph_pkg and vgph_chain (which holds the row of vgph_cell).
// A passed sample appears on the registered output in the cycle after its transaction.
// One sample per cycle while passing or storing, unless the receiver stalls. After a speech
// onset the input stalls while the chain empties: samples held beyond the limit are skipped,
// then the kept ones leave as the burst as the receiver takes them. Synchronous reset.
module voice_gate_preroll_hangover #(
    parameter int PREROLL_DEPTH = vgph_pkg::PREROLL_DEPTH_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [vgph_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [vgph_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic signed [vgph_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic                             i_voice_flag,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [vgph_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                             o_from_preroll,
    output logic                             o_last_of_run
);

    localparam int CNT_W = $clog2(PREROLL_DEPTH + 1);
    localparam int IDX_W = (PREROLL_DEPTH > 1) ? $clog2(PREROLL_DEPTH) : 1;

    localparam logic ST_RUN  = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    // Configuration registers.
    logic                                r_gate_enable;
    logic [vgph_pkg::LIMIT_W-1:0]        r_preroll_limit;
    logic [vgph_pkg::HANGOVER_W-1:0]     r_hangover_length;

    // Control state.
    logic                                r_state, n_state;
    logic                                r_gate_open, n_gate_open;
    logic [vgph_pkg::HANGOVER_W-1:0]     r_hang, n_hang;
    logic [CNT_W-1:0]                    r_count, n_count;   // samples logically kept
    logic [CNT_W-1:0]                    r_fill, n_fill;     // samples physically held
    logic [CNT_W-1:0]                    r_skip, n_skip;
    logic [CNT_W-1:0]                    r_left, n_left;

    // Output register.
    logic                                r_out_valid, n_out_valid;
    logic [vgph_pkg::SAMPLE_W-1:0]       r_out_sample, n_out_sample;
    logic                                r_out_pre, n_out_pre;
    logic                                r_out_last, n_out_last;

    logic                                w_out_free;
    logic                                w_in_fire;
    logic [CNT_W-1:0]                    w_lim;
    logic [CNT_W-1:0]                    w_st_count;
    logic [CNT_W-1:0]                    w_st_fill;
    logic [CNT_W-1:0]                    w_fill_dec;
    logic [IDX_W-1:0]                    w_st_idx;
    logic                                w_st_shift;
    logic                                w_st_wr;
    vgph_pkg::t_chain_ctl                w_ctl;
    logic [vgph_pkg::SAMPLE_W-1:0]       w_head;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_RUN) && w_out_free;
    assign w_in_fire  = i_in_valid && o_in_ready;

    // The limit saturates at the chain depth.
    always_comb begin
        if (32'(r_preroll_limit) > 32'(PREROLL_DEPTH)) begin
            w_lim = CNT_W'(PREROLL_DEPTH);
        end else begin
            w_lim = CNT_W'(r_preroll_limit);
        end
    end

    // Storing a sample: nothing is stored with a zero limit; else append while below the
    // limit, otherwise drop the oldest by shifting and write into the top occupied cell. After
    // the limit was lowered the chain may hold more samples than are kept; the surplus is skipped on onset.
    assign w_fill_dec = r_fill - CNT_W'(1);
    assign w_st_count = (r_count < w_lim) ? (r_count + CNT_W'(1)) : w_lim;

    always_comb begin
        w_st_fill  = r_fill;
        w_st_idx   = r_fill[IDX_W-1:0];
        w_st_shift = 1'b0;
        w_st_wr    = 1'b0;
        if (w_lim == '0) begin
            w_st_fill = '0;
        end else if (r_fill < w_lim) begin
            w_st_fill = r_fill + CNT_W'(1);
            w_st_wr   = 1'b1;
        end else begin
            w_st_idx   = w_fill_dec[IDX_W-1:0];
            w_st_shift = 1'b1;
            w_st_wr    = 1'b1;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_gate_open  = r_gate_open;
        n_hang       = r_hang;
        n_count      = r_count;
        n_fill       = r_fill;
        n_skip       = r_skip;
        n_left       = r_left;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_sample = r_out_sample;
        n_out_pre    = r_out_pre;
        n_out_last   = r_out_last;
        w_ctl        = '0;

        unique case (r_state)
            ST_RUN: begin
                if (w_in_fire) begin
                    if (!r_gate_enable || r_gate_open) begin
                        n_out_valid  = 1'b1;
                        n_out_sample = i_sample_in;
                        n_out_pre    = 1'b0;
                        n_out_last   = 1'b1;
                        if (r_gate_enable) begin
                            if (i_voice_flag) begin
                                n_hang = r_hangover_length;
                            end else if (r_hang > vgph_pkg::HANGOVER_W'(1)) begin
                                n_hang = r_hang - vgph_pkg::HANGOVER_W'(1);
                            end else begin
                                n_hang      = '0;
                                n_gate_open = 1'b0;
                            end
                        end
                    end else begin
                        w_ctl.shift = w_st_shift;
                        w_ctl.wr_en = w_st_wr;
                        n_count     = w_st_count;
                        n_fill      = w_st_fill;
                        if (i_voice_flag) begin
                            n_gate_open = 1'b1;
                            n_hang      = r_hangover_length;
                            if (w_st_count != '0) begin
                                n_state = ST_DUMP;
                                n_skip  = w_st_fill - w_st_count;
                                n_left  = w_st_count;
                            end
                        end
                    end
                end
            end
            ST_DUMP: begin
                // Cell 0 always holds the oldest remaining sample.
                if (r_skip != '0) begin
                    w_ctl.shift = 1'b1;
                    n_skip      = r_skip - CNT_W'(1);
                end else if (w_out_free) begin
                    w_ctl.shift  = 1'b1;
                    n_out_valid  = 1'b1;
                    n_out_sample = w_head;
                    n_out_pre    = 1'b1;
                    n_out_last   = (r_left == CNT_W'(1));
                    n_left       = r_left - CNT_W'(1);
                    if (r_left == CNT_W'(1)) begin
                        n_state = ST_RUN;
                        n_fill  = '0;
                        n_count = '0;
                    end
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    vgph_chain #(
        .DEPTH (PREROLL_DEPTH),
        .IDX_W (IDX_W)
    ) u_chain (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_wr_idx  (w_st_idx),
        .i_wr_data (i_sample_in),
        .o_head    (w_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate_enable     <= vgph_pkg::GATE_ENABLE_RST;
            r_preroll_limit   <= vgph_pkg::PREROLL_LIMIT_RST;
            r_hangover_length <= vgph_pkg::HANGOVER_LENGTH_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                vgph_pkg::REG_GATE_ENABLE: begin
                    r_gate_enable <= i_cfg_wdata[0];
                end
                vgph_pkg::REG_PREROLL_LIMIT: begin
                    r_preroll_limit <= i_cfg_wdata[vgph_pkg::LIMIT_W-1:0];
                end
                vgph_pkg::REG_HANGOVER_LENGTH: begin
                    r_hangover_length <= i_cfg_wdata[vgph_pkg::HANGOVER_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_gate_open <= 1'b0;
            r_hang      <= '0;
            r_count     <= '0;
            r_fill      <= '0;
            r_skip      <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gate_open <= n_gate_open;
            r_hang      <= n_hang;
            r_count     <= n_count;
            r_fill      <= n_fill;
            r_skip      <= n_skip;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_sample <= n_out_sample;
        r_out_pre    <= n_out_pre;
        r_out_last   <= n_out_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample_out   = r_out_sample;
    assign o_from_preroll = r_out_pre;
    assign o_last_of_run  = r_out_last;

endmodule

[verif/vgph_gate_checker.sv]
// Checker for voice_gate_preroll_hangover: follows register writes and both channels,
// predicts every gated sample and compares it with what the block delivers.
// Depends on vgph_pkg for widths, register indexes and reset values.
module vgph_gate_checker
    import vgph_pkg::*;
#(
    parameter int DEPTH = PREROLL_DEPTH_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [SAMPLE_W-1:0]   i_sample_in,
    input  logic                  i_voice_flag,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [SAMPLE_W-1:0]   i_sample_out,
    input  logic                  i_from_preroll,
    input  logic                  i_last_of_run,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                from_preroll;
        logic                last_of_run;
    } gated_sample_t;

    gated_sample_t expected_samples[$];

    // Predicted state of the gate and its registers.
    logic                  cfg_enable;
    logic [LIMIT_W-1:0]    cfg_limit;
    logic [HANGOVER_W-1:0] cfg_hangover;
    logic [SAMPLE_W-1:0]   ring [DEPTH];
    int                    head;
    int                    held;
    logic                  gate_is_open;
    logic [HANGOVER_W-1:0] hang_left;
    int                    fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(string what);
        $display("%0t ns mismatch: %s", $time, what);
        fail_count++;
    endtask

    // Appends one predicted transaction at the tail of the expected list.
    function automatic void add_expected(logic [SAMPLE_W-1:0] s, logic pre, logic last);
        gated_sample_t item;
        item = '{s, pre, last};
        expected_samples.insert(expected_samples.size(), item);
    endfunction

    // Works out the gated samples caused by one input transaction.
    function automatic void predict_gate(logic [SAMPLE_W-1:0] s, logic voice);
        int keep;
        int slot;
        if (!cfg_enable || gate_is_open) begin
            add_expected(s, 1'b0, 1'b1);
            if (!cfg_enable)
                return;
            if (voice)
                hang_left = cfg_hangover;
            else if (hang_left > 1)
                hang_left = hang_left - 1'b1;
            else begin
                hang_left = '0;
                gate_is_open = 1'b0;
            end
            return;
        end
        keep = (cfg_limit > DEPTH) ? DEPTH : int'(cfg_limit);
        ring[head] = s;
        head = (head + 1) % DEPTH;
        if (held < DEPTH)
            held++;
        if (held > keep)
            held = keep;
        if (voice) begin
            gate_is_open = 1'b1;
            hang_left = cfg_hangover;
            // The pre-roll leaves oldest first; the onset sample is the newest.
            for (int k = 0; k < held; k++) begin
                slot = (head + DEPTH - held + k) % DEPTH;
                add_expected(ring[slot], 1'b1, k == held - 1);
            end
            held = 0;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        gated_sample_t want;
        if (!i_rst_n) begin
            cfg_enable   = GATE_ENABLE_RST;
            cfg_limit    = PREROLL_LIMIT_RST;
            cfg_hangover = HANGOVER_LENGTH_RST;
            head         = 0;
            held         = 0;
            gate_is_open = 1'b0;
            hang_left    = '0;
            expected_samples.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_GATE_ENABLE:     cfg_enable   = i_cfg_wdata[0];
                    REG_PREROLL_LIMIT:   cfg_limit    = i_cfg_wdata[LIMIT_W-1:0];
                    REG_HANGOVER_LENGTH: cfg_hangover = i_cfg_wdata[HANGOVER_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                predict_gate(i_sample_in, i_voice_flag);
            if (i_out_valid && i_out_ready) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction, sample %h",
                                              i_sample_out));
                end else begin
                    want = expected_samples[0];
                    expected_samples.delete(0);
                    if (i_sample_out !== want.sample)
                        report_mismatch($sformatf("sample_out %h, want %h",
                                                  i_sample_out, want.sample));
                    if (i_from_preroll !== want.from_preroll)
                        report_mismatch($sformatf("from_preroll %b, want %b on sample %h",
                                                  i_from_preroll, want.from_preroll,
                                                  want.sample));
                    if (i_last_of_run !== want.last_of_run)
                        report_mismatch($sformatf("last_of_run %b, want %b on sample %h",
                                                  i_last_of_run, want.last_of_run,
                                                  want.sample));
                end
            end
            o_pending <= expected_samples.size();
        end
    end

endmodule

[verif/tb_top.sv]
// Top of the voice gate testbench: clock, reset, register writes, sample stimulus
// and receiver stalls. Depends on vgph_pkg, voice_gate_preroll_hangover and
// vgph_gate_checker, which predicts and compares the gated samples.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import vgph_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 150;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // no register behind it

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid  = 1'b0;
    logic signed [SAMPLE_W-1:0] i_sample_in = '0;
    logic                  i_voice_flag = 1'b0;
    logic                  i_out_ready  = 1'b0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic signed [SAMPLE_W-1:0] o_sample_out;
    logic                  o_from_preroll;
    logic                  o_last_of_run;

    int   feed_idle_pct   = 0;
    int   drain_stall_pct = 0;
    logic hold_start      = 1'b0;
    logic drain_hold      = 1'b0;
    int   fail_count;
    int   pending;

    voice_gate_preroll_hangover uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_in    (i_sample_in),
        .i_voice_flag   (i_voice_flag),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sample_out   (o_sample_out),
        .o_from_preroll (o_from_preroll),
        .o_last_of_run  (o_last_of_run)
    );

    vgph_gate_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_sample_in    (i_sample_in),
        .i_voice_flag   (i_voice_flag),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_sample_out   (o_sample_out),
        .i_from_preroll (o_from_preroll),
        .i_last_of_run  (o_last_of_run),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= !drain_hold && ($urandom_range(99) >= drain_stall_pct);
    end

    // Long receiver hold-off, counted here so the sender keeps offering meanwhile.
    always @(posedge i_clk) begin
        if (hold_start) begin
            drain_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            drain_hold <= 1'b0;
        end
    end

    task automatic send_sample(logic [SAMPLE_W-1:0] s, logic voice);
        while ($urandom_range(99) < feed_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_sample_in  <= s;
        i_voice_flag <= voice;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Waits until every predicted sample has come out and the block has gone quiet.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_drained();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idling(int feed_pct, int drain_pct);
        feed_idle_pct   <= feed_pct;
        drain_stall_pct <= drain_pct;
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // Silence into the pre-roll, one voiced onset, then speech with pauses.
    task automatic send_utterance(int quiet_len, int open_len, int voice_pct);
        repeat (quiet_len) send_sample(rand_sample(), 1'b0);
        send_sample(rand_sample(), 1'b1);
        repeat (open_len) send_sample(rand_sample(), $urandom_range(99) < voice_pct);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: ring overflow, onset burst, hangover close, zero limit, zero hangover.
        write_reg(REG_HANGOVER_LENGTH, 20'd2);
        write_reg(REG_PREROLL_LIMIT, 20'd4);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h5555, 1'b0);
        send_sample(16'h2AAA, 1'b1);
        send_sample(16'h1234, 1'b1);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'h8001, 1'b1);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0000, 1'b0);
        write_reg(REG_PREROLL_LIMIT, 20'd0);
        send_sample(16'h4321, 1'b0);
        send_sample(16'hABCD, 1'b1);
        send_sample(16'h1111, 1'b0);
        send_sample(16'h2222, 1'b0);
        write_reg(REG_HANGOVER_LENGTH, 20'd0);
        send_sample(16'h3333, 1'b1);
        send_sample(16'h4444, 1'b1);
        send_sample(16'h5555, 1'b0);
        // Only bit 0 of the enable register counts, so this disables gating.
        write_reg(REG_GATE_ENABLE, 20'hFFFFE);
        write_reg(REG_SPARE, 20'hFFFFF);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h7FFF, 1'b0);
        write_reg(REG_GATE_ENABLE, 20'd1);

        // Random utterances with short pre-roll, no idling on either side.
        set_idling(0, 0);
        write_reg(REG_PREROLL_LIMIT, 20'd6);
        write_reg(REG_HANGOVER_LENGTH, 20'd3);
        repeat (5) send_utterance($urandom_range(0, 8), $urandom_range(0, 6), 30);

        // Sender idles; the limit masks to above the depth, so the full ring is dumped.
        set_idling(69, 0);
        write_reg(REG_PREROLL_LIMIT, 20'hFFFFF);
        write_reg(REG_HANGOVER_LENGTH, 20'd2);
        send_utterance(70, 2, 0);
        repeat (12) send_sample(rand_sample(), 1'b0);

        // Receiver stalls; the limit drops below what the ring holds before the onset.
        set_idling(0, 69);
        write_reg(REG_PREROLL_LIMIT, 20'd5);
        write_reg(REG_HANGOVER_LENGTH, 20'hFFFFF);
        send_utterance(0, 15, 40);
        hold_start <= 1'b1;
        @(posedge i_clk);
        hold_start <= 1'b0;
        repeat (30) send_sample(rand_sample(), 1'($urandom_range(1)));

        // Both sides idle now and then; pass-through, then utterances of random shape.
        set_idling(11, 11);
        write_reg(REG_GATE_ENABLE, 20'd0);
        repeat (8) send_sample(rand_sample(), 1'($urandom_range(1)));
        write_reg(REG_GATE_ENABLE, 20'd1);
        repeat (5) begin
            write_reg(REG_PREROLL_LIMIT, 20'($urandom_range(0, 5)));
            write_reg(REG_HANGOVER_LENGTH, 20'($urandom_range(0, 3)));
            send_utterance($urandom_range(0, 7), $urandom_range(0, 6), 35);
        end

        wait_drained();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
sv/vgph_pkg.sv
sv/vgph_cell.sv
sv/vgph_chain.sv
sv/voice_gate_preroll_hangover.sv
verif/vgph_gate_checker.sv
verif/tb_top.sv
